FILE: sv/mbrp_pkg.sv
`timescale 1ns / 1ps

package mbrp_pkg;

  // Frame layout
  localparam int FRAME_BYTES = 8;
  localparam int CRC_BYTES   = 6;
  localparam int IDX_W       = 4;

  // Protocol constants
  localparam logic [7:0]  READ_HOLDING_FUNC = 8'h03;
  localparam logic [7:0]  HIGHEST_SLAVE     = 8'd247;
  localparam logic [7:0]  BROADCAST_ADDR    = 8'd0;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_DEVICE_ADDR  = 2'd0,
    REG_MAX_QUANTITY = 2'd1,
    REG_ADDR_LIMIT   = 2'd2
  } reg_idx_t;

  localparam logic [7:0]  DEVICE_ADDR_RST  = 8'd0;
  localparam logic [6:0]  MAX_QUANTITY_RST = 7'd125;
  localparam logic [16:0] ADDR_LIMIT_RST   = 17'h10000;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_INVALID   = 3'd2,
    ST_NOT_OURS  = 3'd3,
    ST_WRONG_FN  = 3'd4,
    ST_CRC_ERR   = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0]  device_addr;
    logic [6:0]  max_quantity;
    logic [16:0] addr_limit;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  slave_addr;
    logic [15:0] start_address;
    logic [6:0]  quantity;
  } result_t;

  // Byte-wide reflected CRC-16 update
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: sv/mbrp_regs.sv
`timescale 1ns / 1ps

module mbrp_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [mbrp_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [mbrp_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [mbrp_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                         cfg_pready,
  output mbrp_pkg::cfg_t               cfg
);
  import mbrp_pkg::*;

  logic [7:0]  device_addr_r;
  logic [6:0]  max_quantity_r;
  logic [16:0] addr_limit_r;
  logic        wr_en;
  reg_idx_t    reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = reg_idx_t'(cfg_paddr[PADDR_W-1:2]);

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_addr_r  <= DEVICE_ADDR_RST;
      max_quantity_r <= MAX_QUANTITY_RST;
      addr_limit_r   <= ADDR_LIMIT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DEVICE_ADDR:  device_addr_r  <= cfg_pwdata[7:0];
        REG_MAX_QUANTITY: max_quantity_r <= cfg_pwdata[6:0];
        REG_ADDR_LIMIT:   addr_limit_r   <= cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_DEVICE_ADDR:  cfg_prdata = {24'd0, device_addr_r};
      REG_MAX_QUANTITY: cfg_prdata = {25'd0, max_quantity_r};
      REG_ADDR_LIMIT:   cfg_prdata = {15'd0, addr_limit_r};
      default:          cfg_prdata = '0;
    endcase
  end

  assign cfg.device_addr  = device_addr_r;
  assign cfg.max_quantity = max_quantity_r;
  assign cfg.addr_limit   = addr_limit_r;

endmodule

FILE: sv/mbrp_frame.sv
`timescale 1ns / 1ps

module mbrp_frame (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  mbrp_pkg::cfg_t    cfg,
  output mbrp_pkg::result_t res
);
  import mbrp_pkg::*;

  logic [IDX_W-1:0] byte_idx_r,  byte_idx_nxt;
  logic [15:0]      crc_r,       crc_nxt;
  logic [7:0]       slave_r,     slave_nxt;
  logic [7:0]       func_r,      func_nxt;
  logic [15:0]      start_r,     start_nxt;
  logic [15:0]      count_r,     count_nxt;
  logic [15:0]      rx_crc_r,    rx_crc_nxt;
  logic [16:0]      span;
  logic             in_frame;
  logic             bad_field;
  status_t          status;

  assign in_frame = byte_idx_r < IDX_W'(FRAME_BYTES);

  // Capture the byte into its field and advance the CRC
  always_comb begin
    slave_nxt    = slave_r;
    func_nxt     = func_r;
    start_nxt    = start_r;
    count_nxt    = count_r;
    rx_crc_nxt   = rx_crc_r;
    crc_nxt      = crc_r;
    byte_idx_nxt = byte_idx_r;
    if (in_frame) begin
      case (byte_idx_r)
        4'd0: slave_nxt  = data_byte;
        4'd1: func_nxt   = data_byte;
        4'd2: start_nxt  = {data_byte, 8'h00};
        4'd3: start_nxt  = {start_r[15:8], data_byte};
        4'd4: count_nxt  = {data_byte, 8'h00};
        4'd5: count_nxt  = {count_r[15:8], data_byte};
        4'd6: rx_crc_nxt = {8'h00, data_byte};
        default: rx_crc_nxt = {data_byte, rx_crc_r[7:0]};
      endcase
      if (byte_idx_r < IDX_W'(CRC_BYTES)) begin
        crc_nxt = crc16_byte(crc_r, data_byte);
      end
      byte_idx_nxt = byte_idx_r + IDX_W'(1);
    end
  end

  // Check the frame in priority order
  assign span      = {1'b0, start_nxt} + {1'b0, count_nxt};
  assign bad_field = (count_nxt == 16'd0) || (count_nxt > {9'd0, cfg.max_quantity})
                  || (slave_nxt > HIGHEST_SLAVE) || (span > cfg.addr_limit);

  always_comb begin
    if (byte_idx_nxt < IDX_W'(FRAME_BYTES))                          status = ST_SHORT;
    else if (bad_field)                                              status = ST_INVALID;
    else if (slave_nxt != cfg.device_addr && slave_nxt != BROADCAST_ADDR)
                                                                     status = ST_NOT_OURS;
    else if (func_nxt != READ_HOLDING_FUNC)                          status = ST_WRONG_FN;
    else if (crc_nxt != rx_crc_nxt)                                  status = ST_CRC_ERR;
    else                                                             status = ST_OK;
  end

  assign res.status        = status;
  assign res.slave_addr    = (status == ST_OK) ? slave_nxt      : 8'd0;
  assign res.start_address = (status == ST_OK) ? start_nxt      : 16'd0;
  assign res.quantity      = (status == ST_OK) ? count_nxt[6:0] : 7'd0;

  // Hold frame state; clear it after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      byte_idx_r <= '0;
      crc_r      <= CRC_INIT;
      slave_r    <= '0;
      func_r     <= '0;
      start_r    <= '0;
      count_r    <= '0;
      rx_crc_r   <= '0;
    end else if (step) begin
      byte_idx_r <= byte_idx_nxt;
      crc_r      <= crc_nxt;
      slave_r    <= slave_nxt;
      func_r     <= func_nxt;
      start_r    <= start_nxt;
      count_r    <= count_nxt;
      rx_crc_r   <= rx_crc_nxt;
    end
  end

  a_idx_sat: assert property (@(posedge clk) disable iff (!rst_n)
    byte_idx_r <= IDX_W'(FRAME_BYTES))
    else $error("byte index past frame length");

  a_idx_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_byte |=> byte_idx_r == '0 && crc_r == CRC_INIT)
    else $error("frame state not cleared after last byte");

  a_crc_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    step && !last_byte && byte_idx_r >= IDX_W'(CRC_BYTES) |=> $stable(crc_r))
    else $error("crc advanced past covered bytes");

endmodule

FILE: sv/modbus_read_request_parser.sv
`timescale 1ns / 1ps
// Modbus RTU read-holding-registers request parser.
// Input channel: one frame byte per transaction (in_data_byte, in_last_byte),
// valid/ready handshake; in_last_byte marks the final byte of the frame.
// Result channel: exactly one transaction per frame, after its last byte,
// carrying out_status and the decoded slave address, start address and
// quantity (fields are zero unless the status is ok).
// Configuration: APB-style port, registers device_address (0x0),
// max_quantity (0x4) and address_limit (0x8); write only while idle.
// Throughput: one byte per cycle while no last byte is stalled. Each byte
// passes an input register, then a single pass of field capture, byte-wide
// CRC update and checks, and the result lands in the output register with
// out_valid. The CRC update on the input register is the longest path.
// Reset: clears the frame state and loads register defaults (address 0,
// quantity limit 125, address limit 65536); no result is pending.
// Stall: while a result waits on out_ready, non-last bytes keep flowing;
// a last byte waits in the input register until the output register frees.
module modbus_read_request_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_data_byte,
  input  logic                         in_last_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   out_status,
  output logic [7:0]                   out_slave_addr,
  output logic [15:0]                  out_start_address,
  output logic [6:0]                   out_quantity,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [mbrp_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [mbrp_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [mbrp_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                         cfg_pready
);
  import mbrp_pkg::*;

  cfg_t        cfg;
  result_t     res;
  result_t     out_res_r;
  logic        out_valid_r;
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        s1_consume;

  mbrp_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Consume the held byte unless it ends a frame and the result slot is busy
  assign s1_consume = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_consume;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  mbrp_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_consume),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .cfg       (cfg),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_consume && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_consume && s1_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_slave_addr    = out_res_r.slave_addr;
  assign out_start_address = out_res_r.start_address;
  assign out_quantity      = out_res_r.quantity;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(s1_consume && s1_last_r))
    else $error("pending result overwritten");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status != ST_OK |->
      out_res_r.slave_addr == 8'd0 && out_res_r.start_address == 16'd0
      && out_res_r.quantity == 7'd0)
    else $error("decoded fields nonzero on error");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_consume |=> s1_valid_r && $stable(s1_byte_r) && $stable(s1_last_r))
    else $error("held byte lost while stalled");

endmodule

FILE: verif/modbus_read_request_parser_tb.sv
`timescale 1ns / 1ps

module modbus_read_request_parser_tb;
  import mbrp_pkg::*;

  // Tracks the parser state byte by byte and holds the replies it owes
  class request_checker;
    logic [7:0]  dev_addr   = DEVICE_ADDR_RST;
    logic [6:0]  max_qty    = MAX_QUANTITY_RST;
    logic [16:0] addr_limit = ADDR_LIMIT_RST;

    int unsigned pos      = 0;
    logic [15:0] crc_acc  = CRC_INIT;
    logic [7:0]  f_slave  = '0;
    logic [7:0]  f_func   = '0;
    logic [15:0] f_start  = '0;
    logic [15:0] f_count  = '0;
    logic [15:0] f_crc_rx = '0;

    result_t expected_replies[$];
    int errors = 0;
    int seen[6] = '{default: 0};

    static function logic [15:0] crc_update(logic [15:0] acc, logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      repeat (8) c = (c >> 1) ^ (c[0] ? CRC_POLY : 16'h0000);
      return c;
    endfunction

    function void set_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
      case (addr[PADDR_W-1:2])
        REG_DEVICE_ADDR:  dev_addr   = data[7:0];
        REG_MAX_QUANTITY: max_qty    = data[6:0];
        REG_ADDR_LIMIT:   addr_limit = data[16:0];
        default: ;
      endcase
    endfunction

    // Capture one frame byte; on the last byte queue the reply it must produce
    function void take_byte(logic [7:0] b, logic last);
      result_t     r;
      logic [16:0] reach;
      if (pos < FRAME_BYTES) begin
        case (pos)
          0: f_slave = b;
          1: f_func = b;
          2: f_start[15:8] = b;
          3: f_start[7:0] = b;
          4: f_count[15:8] = b;
          5: f_count[7:0] = b;
          6: f_crc_rx[7:0] = b;
          default: f_crc_rx[15:8] = b;
        endcase
        if (pos < CRC_BYTES) crc_acc = crc_update(crc_acc, b);
        pos++;
      end
      if (!last) return;

      reach = {1'b0, f_start} + {1'b0, f_count};
      r = '0;
      if (pos < FRAME_BYTES)
        r.status = ST_SHORT;
      else if (f_count == 0 || f_count > max_qty || f_slave > HIGHEST_SLAVE ||
               reach > addr_limit)
        r.status = ST_INVALID;
      else if (f_slave != dev_addr && f_slave != BROADCAST_ADDR)
        r.status = ST_NOT_OURS;
      else if (f_func != READ_HOLDING_FUNC)
        r.status = ST_WRONG_FN;
      else if (crc_acc != f_crc_rx)
        r.status = ST_CRC_ERR;
      else
        r.status = ST_OK;

      if (r.status == ST_OK) begin
        r.slave_addr    = f_slave;
        r.start_address = f_start;
        r.quantity      = f_count[6:0];
      end
      expected_replies.push_back(r);
      seen[r.status]++;

      // Start over for the next frame
      pos      = 0;
      crc_acc  = CRC_INIT;
      f_slave  = '0;
      f_func   = '0;
      f_start  = '0;
      f_count  = '0;
      f_crc_rx = '0;
    endfunction

    function void match_reply(logic [2:0] st, logic [7:0] sa, logic [15:0] sadr,
                              logic [6:0] q);
      result_t want;
      if (expected_replies.size() == 0) begin
        errors++;
        $error("reply with no frame pending: status %0d", st);
        return;
      end
      want = expected_replies.pop_front();
      if (st !== want.status) begin
        errors++;
        $error("status: expected %0d, got %0d", want.status, st);
      end
      if (sa !== want.slave_addr) begin
        errors++;
        $error("slave_addr: expected %0d, got %0d", want.slave_addr, sa);
      end
      if (sadr !== want.start_address) begin
        errors++;
        $error("start_address: expected %0d, got %0d", want.start_address, sadr);
      end
      if (q !== want.quantity) begin
        errors++;
        $error("quantity: expected %0d, got %0d", want.quantity, q);
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 200000;
  localparam int NPHASE      = 6;
  localparam int MAX_FRAME   = 16;
  localparam logic [PADDR_W-1:0] SPARE_ADDR = 4'hC;

  // Per-phase register values, idle and stall rates, and byte budgets
  logic [7:0]  ph_dev   [NPHASE] = '{8'h11, 8'd247, 8'd0, 8'd255, 8'd93, 8'd200};
  logic [6:0]  ph_max   [NPHASE] = '{7'd125, 7'd1, 7'd125, 7'd0, 7'd37, 7'd125};
  logic [16:0] ph_lim   [NPHASE] = '{17'd65536, 17'd1, 17'h1FFFF, 17'd0, 17'd300,
                                     17'd65536};
  int          ph_idle  [NPHASE] = '{0, 85, 0, 0, 24, 0};
  int          ph_stall [NPHASE] = '{0, 0, 85, 0, 24, 85};
  int          ph_bytes [NPHASE] = '{250, 200, 250, 80, 300, 200};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_data_byte = '0;
  logic               in_last_byte = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_status;
  logic [7:0]         out_slave_addr;
  logic [15:0]        out_start_address;
  logic [6:0]         out_quantity;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [PDATA_W-1:0] cfg_pwdata = '0;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  request_checker sb = new();

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int cycle_count   = 0;
  int bytes_sent    = 0;

  logic [7:0] frame_buf [MAX_FRAME];
  int         req_len = 0;

  modbus_read_request_parser DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_slave_addr    (out_slave_addr),
    .out_start_address (out_start_address),
    .out_quantity      (out_quantity),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  always #2 clk = ~clk;

  // Stall the reply channel at the current rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Observe both channels on the edge where each transaction completes
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.take_byte(in_data_byte, in_last_byte);
      if (out_valid && out_ready)
        sb.match_reply(out_status, out_slave_addr, out_start_address, out_quantity);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
               sb.expected_replies.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_reg(addr, data);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_check(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] want);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== want) begin
      sb.errors++;
      $error("register 0x%0h readback: expected 0x%0h, got 0x%0h", addr, want, cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] dev, input logic [6:0] maxq,
                                input logic [16:0] lim);
    cfg_write({REG_DEVICE_ADDR, 2'b00}, PDATA_W'(dev));
    cfg_write({REG_MAX_QUANTITY, 2'b00}, PDATA_W'(maxq));
    cfg_write({REG_ADDR_LIMIT, 2'b00}, PDATA_W'(lim));
    cfg_check({REG_DEVICE_ADDR, 2'b00}, PDATA_W'(dev));
    cfg_check({REG_MAX_QUANTITY, 2'b00}, PDATA_W'(maxq));
    cfg_check({REG_ADDR_LIMIT, 2'b00}, PDATA_W'(lim));
  endtask

  // Offer one byte, idling first at the current rate; return once accepted
  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_frame();
    for (int i = 0; i < req_len; i++) push_byte(frame_buf[i], i == req_len - 1);
    bytes_sent += req_len;
  endtask

  // Hold the input until every owed reply is out, then let the pipe settle
  task automatic drain(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_replies.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  function automatic void build_request(input logic [7:0] slave, input logic [7:0] fn,
                                        input logic [15:0] start, input logic [15:0] qty);
    logic [15:0] crc;
    frame_buf[0] = slave;
    frame_buf[1] = fn;
    frame_buf[2] = start[15:8];
    frame_buf[3] = start[7:0];
    frame_buf[4] = qty[15:8];
    frame_buf[5] = qty[7:0];
    crc = CRC_INIT;
    for (int i = 0; i < CRC_BYTES; i++) crc = request_checker::crc_update(crc, frame_buf[i]);
    frame_buf[6] = crc[7:0];
    frame_buf[7] = crc[15:8];
    req_len = FRAME_BYTES;
  endfunction

  // Well-formed requests for the current registers, plus broken ones
  function automatic void make_random_frame();
    int unsigned pick, maxq, lim, top, span;
    logic [7:0]  slave, fn;
    logic [15:0] start, qty;
    maxq = sb.max_qty;
    lim  = sb.addr_limit;
    pick = $urandom_range(99);

    top  = (maxq < lim) ? maxq : lim;
    qty  = (top == 0) ? 16'($urandom_range(1, 125)) : 16'($urandom_range(1, top));
    span = (lim > qty) ? lim - qty : 0;
    if (span > 65535) span = 65535;
    start = ($urandom_range(3) == 0) ? 16'(span) : 16'($urandom_range(0, span));
    if (sb.dev_addr == BROADCAST_ADDR || sb.dev_addr > HIGHEST_SLAVE ||
        $urandom_range(4) == 0)
      slave = BROADCAST_ADDR;
    else
      slave = sb.dev_addr;
    fn = READ_HOLDING_FUNC;

    // Break one field
    if (pick >= 45 && pick < 50) begin
      slave = 8'($urandom_range(HIGHEST_SLAVE + 1, 255));
    end else if (pick >= 50 && pick < 55) begin
      qty = '0;
    end else if (pick >= 55 && pick < 60) begin
      qty = 16'($urandom_range(maxq + 1, $urandom_range(1) ? 255 : 65535));
    end else if (pick >= 60 && pick < 65) begin
      if (lim >= qty && lim - qty + 1 <= 65535)
        start = 16'($urandom_range(lim - qty + 1, 65535));
    end else if (pick >= 65 && pick < 72) begin
      slave = 8'($urandom_range(1, HIGHEST_SLAVE));
      if (slave == sb.dev_addr) slave = (slave == HIGHEST_SLAVE) ? 8'd1 : slave + 8'd1;
    end else if (pick >= 72 && pick < 78) begin
      fn = 8'($urandom_range(255));
      if (fn == READ_HOLDING_FUNC) fn = 8'h04;
    end
    build_request(slave, fn, start, qty);

    // Or break the framing
    if (pick >= 78 && pick < 85) begin
      frame_buf[6 + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
    end else if (pick >= 85 && pick < 91) begin
      req_len = $urandom_range(1, FRAME_BYTES - 1);
    end else if (pick >= 91 && pick < 96) begin
      req_len = FRAME_BYTES + $urandom_range(1, 4);
      for (int i = FRAME_BYTES; i < req_len; i++) frame_buf[i] = 8'($urandom);
    end else if (pick >= 96) begin
      req_len = $urandom_range(1, 12);
      for (int i = 0; i < req_len; i++) frame_buf[i] = 8'($urandom);
    end
  endfunction

  initial begin
    int target;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames under reset register values
    build_request(BROADCAST_ADDR, READ_HOLDING_FUNC, 16'h0000, 16'h0001);
    send_frame();
    frame_buf[0] = 8'h00;
    req_len = 1;
    send_frame();
    build_request(HIGHEST_SLAVE, READ_HOLDING_FUNC, 16'hFFFF, 16'h0001);
    send_frame();
    build_request(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_frame();
    drain(8);

    // Writes to an unmapped address must not disturb anything
    cfg_write(SPARE_ADDR, $urandom);

    for (int p = 0; p < NPHASE; p++) begin
      apply_settings(ph_dev[p], ph_max[p], ph_lim[p]);
      send_idle_pct = ph_idle[p];
      stall_pct     = ph_stall[p];
      target        = bytes_sent + ph_bytes[p];
      while (bytes_sent < target) begin
        make_random_frame();
        send_frame();
        if ($urandom_range(39) == 0) drain(0);
      end
      drain(8);
    end

    stall_pct = 0;
    drain(16);
    $display("Sent %0d bytes over %0d register settings under four idle patterns",
             bytes_sent, NPHASE + 1);
    $display({"Replies by status: ok %0d, short %0d, invalid %0d, not ours %0d,",
              " bad fn %0d, bad crc %0d"},
             sb.seen[ST_OK], sb.seen[ST_SHORT], sb.seen[ST_INVALID],
             sb.seen[ST_NOT_OURS], sb.seen[ST_WRONG_FN], sb.seen[ST_CRC_ERR]);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
